// ===== rtl/aes256_cbc_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// aes256 cbc cipher assertion macros
// shared property forms for the cipher block
// ----------------------------------------------------------------------------
`ifndef AES256_CBC_CIPHER_ASSERT_SVH
`define AES256_CBC_CIPHER_ASSERT_SVH

// same-cycle implication
`define ACBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ACBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/acbc_pkg.sv =====
// ----------------------------------------------------------------------------
// acbc_pkg
// aes tables and round functions for the cbc cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acbc_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int RK_WORDS    = 4 * (ROUND_COUNT + 1);
    localparam int RK_ROWS     = ROUND_COUNT + 1;
    localparam int ROW_AW      = $clog2(RK_ROWS);
    localparam int CFG_IW      = 3;

    localparam logic [CFG_IW-1:0] REG_KEY_A = 3'd0;
    localparam logic [CFG_IW-1:0] REG_KEY_B = 3'd1;
    localparam logic [CFG_IW-1:0] REG_KEY_C = 3'd2;
    localparam logic [CFG_IW-1:0] REG_KEY_D = 3'd3;
    localparam logic [CFG_IW-1:0] REG_IV_HI = 3'd4;
    localparam logic [CFG_IW-1:0] REG_IV_LO = 3'd5;
    localparam logic [CFG_IW-1:0] REG_DIR   = 3'd6;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
        8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
        8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
        8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
        8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
        8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
        8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
        8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
        8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
        8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
        8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
        8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38, 8'hbf, 8'h40, 8'ha3, 8'h9e,
        8'h81, 8'hf3, 8'hd7, 8'hfb, 8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb, 8'h54, 8'h7b, 8'h94, 8'h32,
        8'ha6, 8'hc2, 8'h23, 8'h3d, 8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2, 8'h76, 8'h5b, 8'ha2, 8'h49,
        8'h6d, 8'h8b, 8'hd1, 8'h25, 8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92, 8'h6c, 8'h70, 8'h48, 8'h50,
        8'hfd, 8'hed, 8'hb9, 8'hda, 8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a, 8'hf7, 8'he4, 8'h58, 8'h05,
        8'hb8, 8'hb3, 8'h45, 8'h06, 8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b, 8'h3a, 8'h91, 8'h11, 8'h41,
        8'h4f, 8'h67, 8'hdc, 8'hea, 8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85, 8'he2, 8'hf9, 8'h37, 8'he8,
        8'h1c, 8'h75, 8'hdf, 8'h6e, 8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b, 8'hfc, 8'h56, 8'h3e, 8'h4b,
        8'hc6, 8'hd2, 8'h79, 8'h20, 8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31, 8'hb1, 8'h12, 8'h10, 8'h59,
        8'h27, 8'h80, 8'hec, 8'h5f, 8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef, 8'ha0, 8'he0, 8'h3b, 8'h4d,
        8'hae, 8'h2a, 8'hf5, 8'hb0, 8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26, 8'he1, 8'h69, 8'h14, 8'h63,
        8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // byte i of the block sits at bits 127-8i downto 120-8i
    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
        logic [7:0]   t [16];
        logic [7:0]   a, b, d, e;
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*c+r] = SBOX[s[127 - 8*(4*((c+r)%4)+r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
            if (mix)
            begin
                o[127 - 32*c      -: 8] = xt(a) ^ xt(b) ^ b ^ d ^ e;
                o[127 - 32*c - 8  -: 8] = xt(b) ^ xt(d) ^ d ^ e ^ a;
                o[127 - 32*c - 16 -: 8] = xt(d) ^ xt(e) ^ e ^ a ^ b;
                o[127 - 32*c - 24 -: 8] = xt(e) ^ xt(a) ^ a ^ b ^ d;
            end
            else
            begin
                o[127 - 32*c -: 32] = {a, b, d, e};
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_round(input logic [127:0] s, input logic mix);
        logic [7:0]   m [16];
        logic [7:0]   a, b, d, e;
        logic [7:0]   a2, a4, a8, b2, b4, b8, d2, d4, d8, e2, e4, e8;
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a = s[127 - 32*c -: 8];      b = s[119 - 32*c -: 8];
            d = s[111 - 32*c -: 8];      e = s[103 - 32*c -: 8];
            a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
            b2 = xt(b); b4 = xt(b2); b8 = xt(b4);
            d2 = xt(d); d4 = xt(d2); d8 = xt(d4);
            e2 = xt(e); e4 = xt(e2); e8 = xt(e4);
            if (mix)
            begin
                m[4*c]   = (a8^a4^a2) ^ (b8^b2^b) ^ (d8^d4^d) ^ (e8^e);
                m[4*c+1] = (a8^a) ^ (b8^b4^b2) ^ (d8^d2^d) ^ (e8^e4^e);
                m[4*c+2] = (a8^a4^a) ^ (b8^b) ^ (d8^d4^d2) ^ (e8^e2^e);
                m[4*c+3] = (a8^a2^a) ^ (b8^b4^b) ^ (d8^d) ^ (e8^e4^e2);
            end
            else
            begin
                m[4*c] = a; m[4*c+1] = b; m[4*c+2] = d; m[4*c+3] = e;
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8*(4*((c+r)%4)+r) -: 8] = SBOX_REV[m[4*c+r]];
            end
        end
        return o;
    endfunction

endpackage

// ===== rtl/aes256_cbc_cipher.sv =====
// a block passes through the load state, the 14 rounds of the run state and the
// flush state, which waits until the output register is free; no new request is
// taken until the single shared round unit is done, and only in the idle state
// the round-key ram is filled by a 60-word expansion after reset and after every
// key write; no input is taken meanwhile
// reset clears chain value, key, iv and direction; expansion of the zero key follows
// ----------------------------------------------------------------------------
// aes256_cbc_cipher
// aes-256 cbc encrypt / decrypt, one round per cycle on a shared round unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes256_cbc_cipher_assert.svh"

module aes256_cbc_cipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_lo, block_hi
    input  logic         s_axis_tuser,   // first_block
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // result_lo, result_hi
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_FLUSH} state_t;

    state_t       state_reg;
    logic [63:0]  key_reg [4];
    logic [127:0] iv_reg, chain_reg, chain_sel_reg, blk_reg, s_reg, out_reg;
    logic         dir_reg, dir_run_reg, out_valid_reg;
    logic [3:0]   cnt_reg;
    logic [acbc_pkg::ROW_AW-1:0] raddr;
    logic [127:0] rk, round_out, s_in;
    logic         kbusy, key_wr, cfg_wr, in_acc, out_free;

    assign cfg_wr   = cfg_valid;
    assign key_wr   = cfg_wr && (cfg_index == acbc_pkg::REG_KEY_A ||
                      cfg_index == acbc_pkg::REG_KEY_B || cfg_index == acbc_pkg::REG_KEY_C ||
                      cfg_index == acbc_pkg::REG_KEY_D);
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && !kbusy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_in          = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            raddr = dir_reg ? 4'(acbc_pkg::ROUND_COUNT) : 4'd0;
        end
        else
        begin
            raddr = dir_run_reg ? 4'(4'd13 - cnt_reg) : 4'(cnt_reg + 4'd1);
        end
        if (dir_run_reg)
        begin
            round_out = acbc_pkg::inv_round(s_reg, cnt_reg != 4'd1) ^ rk;
        end
        else
        begin
            round_out = acbc_pkg::fwd_round(s_reg, cnt_reg != 4'(acbc_pkg::ROUND_COUNT)) ^ rk;
        end
    end

    acbc_key_sched u_key_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .restart(key_wr),
        .busy   (kbusy),
        .rd_addr(raddr),
        .rd_data(rk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            dir_reg       <= 1'b0;
            dir_run_reg   <= 1'b0;
            iv_reg        <= '0;
            chain_reg     <= '0;
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    acbc_pkg::REG_KEY_A: key_reg[0] <= cfg_data;
                    acbc_pkg::REG_KEY_B: key_reg[1] <= cfg_data;
                    acbc_pkg::REG_KEY_C: key_reg[2] <= cfg_data;
                    acbc_pkg::REG_KEY_D: key_reg[3] <= cfg_data;
                    acbc_pkg::REG_IV_HI: iv_reg[127:64] <= cfg_data;
                    acbc_pkg::REG_IV_LO: iv_reg[63:0] <= cfg_data;
                    acbc_pkg::REG_DIR:   dir_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tready && !(state_reg == ST_FLUSH && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        dir_run_reg <= dir_reg;
                        cnt_reg     <= '0;
                        state_reg   <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg   <= 4'd1;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (cnt_reg == 4'(acbc_pkg::ROUND_COUNT))
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        chain_reg     <= dir_run_reg ? blk_reg : s_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    blk_reg       <= s_in;
                    chain_sel_reg <= s_axis_tuser ? iv_reg : chain_reg;
                end
            end
            ST_LOAD: s_reg <= blk_reg ^ (dir_run_reg ? 128'h0 : chain_sel_reg) ^ rk;
            ST_RUN:
            begin
                if (cnt_reg == 4'(acbc_pkg::ROUND_COUNT) && dir_run_reg)
                begin
                    s_reg <= round_out ^ chain_sel_reg;
                end
                else
                begin
                    s_reg <= round_out;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_reg <= s_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

    `ACBC_ASSERT_SAME(a_ready_no_expand, s_axis_tready, !kbusy)
    `ACBC_ASSERT_NEXT(a_accept_loads, in_acc, state_reg == ST_LOAD)
    `ACBC_ASSERT_SAME(a_round_range, state_reg == ST_RUN, cnt_reg >= 4'd1 && cnt_reg <= 4'd14)
    `ACBC_ASSERT_NEXT(a_key_write_expands, key_wr, kbusy && !s_axis_tready)

endmodule

// ===== rtl/acbc_ram.sv =====
// ----------------------------------------------------------------------------
// acbc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/acbc_key_sched.sv =====
// ----------------------------------------------------------------------------
// acbc_key_sched
// aes-256 key expansion, one word per cycle, into a round-key ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acbc_key_sched (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [255:0]                key,
    input  logic                        restart,
    output logic                        busy,
    input  logic [acbc_pkg::ROW_AW-1:0] rd_addr,
    output logic [127:0]                rd_data
);

    localparam int LAST_WORD = acbc_pkg::RK_WORDS - 1;

    logic        busy_reg;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] win_reg [8];
    logic [31:0] temp, new_word, key_word;
    logic        wr_en;

    always_comb
    begin
        key_word = key[255 - 32*idx_reg[2:0] -: 32];
        temp     = win_reg[7];
        rc_next  = rc_reg;
        if (idx_reg[2:0] == 3'd0)
        begin
            temp = acbc_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                   ^ {rc_reg, 24'h0};
            if (idx_reg >= 6'd8)
            begin
                rc_next = acbc_pkg::xt(rc_reg);
            end
        end
        else if (idx_reg[2:0] == 3'd4)
        begin
            temp = acbc_pkg::sub_word(win_reg[7]);
        end
        new_word = (idx_reg < 6'd8) ? key_word : (win_reg[0] ^ temp);
        wr_en    = busy_reg && (idx_reg[1:0] == 2'd3);
        idx_next = idx_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rc_reg   <= acbc_pkg::RCON_FIRST;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rc_reg   <= acbc_pkg::RCON_FIRST;
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_next;
            rc_reg  <= (idx_reg < 6'd8) ? acbc_pkg::RCON_FIRST : rc_next;
            if (idx_reg == 6'(LAST_WORD))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart)
        begin
            for (int k = 0; k < 7; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[7] <= new_word;
        end
    end

    acbc_ram #(
        .WIDTH(128),
        .DEPTH(acbc_pkg::RK_ROWS)
    ) u_rk_ram (
        .clk  (clk),
        .we   (wr_en && !restart),
        .waddr(idx_reg[5:2]),
        .wdata({win_reg[5], win_reg[6], win_reg[7], new_word}),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign busy = busy_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives aes-256 cbc requests and key, iv and direction writes into the
// cipher and checks each result block against an in-bench aes-256 cbc
// predictor or known answer; directed rows come first, then random messages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          first;
        bit          known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    // predictor state
    logic [63:0]  key_word [4];
    logic [63:0]  iv_word [2];
    logic         decrypt_mode;
    logic [127:0] chain_block;
    logic [31:0]  sched [60];

    logic [127:0] pending_blocks [$];
    int           errors = 0;
    int           cycles = 0;
    bit           quiet = 1'b0;

    aes256_cbc_cipher uut (.*);

    always #2 clk = ~clk;

    function automatic logic [7:0] gf2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= a;
            a = gf2(a);
        end
        return acc;
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            sched[i] = (i % 2) ? key_word[i/2][31:0] : key_word[i/2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = sched[i-1];
            if (i % 8 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {acbc_pkg::SBOX[t[31:24]], acbc_pkg::SBOX[t[23:16]],
                     acbc_pkg::SBOX[t[15:8]], acbc_pkg::SBOX[t[7:0]]}
                    ^ {rc, 24'h0};
                rc = gf2(rc);
            end
            else if (i % 8 == 4)
                t = {acbc_pkg::SBOX[t[31:24]], acbc_pkg::SBOX[t[23:16]],
                     acbc_pkg::SBOX[t[15:8]], acbc_pkg::SBOX[t[7:0]]};
            sched[i] = sched[i-8] ^ t;
        end
    endfunction

    function automatic logic [127:0] run_cipher(input logic [127:0] blk, input bit inv);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a, b, d, e;
        logic [127:0] o;
        for (int k = 0; k < 16; k++)
            s[k] = blk[127-8*k -: 8];
        for (int step = 0; step <= 14; step++)
        begin
            int rnd;
            rnd = inv ? 14 - step : step;
            if (step > 0 && !inv)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*c+r] = acbc_pkg::SBOX[s[4*((c+r)%4)+r]];
                for (int c = 0; c < 4; c++)
                begin
                    a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
                    if (rnd != 14)
                    begin
                        s[4*c]   = gf2(a) ^ gf2(b) ^ b ^ d ^ e;
                        s[4*c+1] = gf2(b) ^ gf2(d) ^ d ^ e ^ a;
                        s[4*c+2] = gf2(d) ^ gf2(e) ^ e ^ a ^ b;
                        s[4*c+3] = gf2(e) ^ gf2(a) ^ a ^ b ^ d;
                    end
                    else
                    begin
                        s[4*c] = a; s[4*c+1] = b; s[4*c+2] = d; s[4*c+3] = e;
                    end
                end
            end
            else if (step > 0)
            begin
                if (rnd != 13)
                    for (int c = 0; c < 4; c++)
                    begin
                        a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
                        s[4*c]   = gf_times(a, 8'h0e) ^ gf_times(b, 8'h0b)
                                 ^ gf_times(d, 8'h0d) ^ gf_times(e, 8'h09);
                        s[4*c+1] = gf_times(a, 8'h09) ^ gf_times(b, 8'h0e)
                                 ^ gf_times(d, 8'h0b) ^ gf_times(e, 8'h0d);
                        s[4*c+2] = gf_times(a, 8'h0d) ^ gf_times(b, 8'h09)
                                 ^ gf_times(d, 8'h0e) ^ gf_times(e, 8'h0b);
                        s[4*c+3] = gf_times(a, 8'h0b) ^ gf_times(b, 8'h0d)
                                 ^ gf_times(d, 8'h09) ^ gf_times(e, 8'h0e);
                    end
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*((c+r)%4)+r] = acbc_pkg::SBOX_REV[s[4*c+r]];
                s = t;
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4*c+r] ^= sched[4*rnd+c][31-8*r -: 8];
        end
        for (int k = 0; k < 16; k++)
            o[127-8*k -: 8] = s[k];
        return o;
    endfunction

    // returns the expected block and advances the chain
    function automatic logic [127:0] cbc_next(input logic [127:0] blk, input bit first);
        logic [127:0] link;
        logic [127:0] o;
        link = first ? {iv_word[0], iv_word[1]} : chain_block;
        if (!decrypt_mode)
        begin
            o = run_cipher(blk ^ link, 1'b0);
            chain_block = o;
        end
        else
        begin
            o = run_cipher(blk, 1'b1) ^ link;
            chain_block = blk;
        end
        return o;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            acbc_pkg::REG_KEY_A, acbc_pkg::REG_KEY_B, acbc_pkg::REG_KEY_C,
            acbc_pkg::REG_KEY_D:
            begin
                key_word[idx] = v;
                build_schedule();
            end
            acbc_pkg::REG_IV_HI: iv_word[0] = v;
            acbc_pkg::REG_IV_LO: iv_word[1] = v;
            acbc_pkg::REG_DIR:   decrypt_mode = v[0];
            default: ;
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 7);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_write(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit first,
                              input bit known, input logic [63:0] eh, input logic [63:0] el);
        logic [127:0] want;
        if (idle_now())
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = cbc_next({hi, lo}, first);
        pending_blocks.push_back(known ? {eh, el} : want);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // result side
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_blocks.size() == 0)
            begin
                report("unexpected result", m_axis_tdata[63:0], '0);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64])
                    report("result_hi", m_axis_tdata[63:0], want[127:64]);
                if (m_axis_tdata[127:64] !== want[63:0])
                    report("result_lo", m_axis_tdata[127:64], want[63:0]);
            end
        end
        m_axis_tready <= rst_n && !idle_now();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    row_t directed [] = '{
        // zero key, zero chain, no first block yet
        '{0, 0, 64'h0, 64'h0, 0, 1, 64'hdc95c078a2408989, 64'had48a21492842087},
        '{0, 0, 64'h0, 64'h0, 1, 1, 64'hdc95c078a2408989, 64'had48a21492842087},
        '{0, 0, '1, '1, 0, 0, 0, 0},
        '{0, 0, '1, 64'h0, 1, 0, 0, 0},
        '{1, acbc_pkg::REG_KEY_A, 64'h0001020304050607, 0, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_KEY_B, 64'h08090a0b0c0d0e0f, 0, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_KEY_C, 64'h1011121314151617, 0, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_KEY_D, 64'h18191a1b1c1d1e1f, 0, 0, 0, 0, 0},
        '{0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1, 1,
          64'h8ea2b7ca516745bf, 64'heafc49904b496089},
        '{0, 0, 64'h0, '1, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_DIR, 64'h1, 0, 0, 0, 0, 0},
        '{0, 0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1, 1,
          64'h0011223344556677, 64'h8899aabbccddeeff},
        '{0, 0, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0, 0},
        // direction change in the middle of a message
        '{1, acbc_pkg::REG_DIR, 64'hfffffffffffffffe, 0, 0, 0, 0, 0},
        '{0, 0, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_IV_HI, '1, 0, 0, 0, 0, 0},
        '{1, acbc_pkg::REG_IV_LO, 64'h8000000000000001, 0, 0, 0, 0, 0},
        '{1, REG_SPARE, '1, 0, 0, 0, 0, 0},
        '{0, 0, 64'h0, 64'h0, 1, 0, 0, 0},
        '{1, acbc_pkg::REG_DIR, '1, 0, 0, 0, 0, 0},
        '{0, 0, '1, '1, 1, 0, 0, 0},
        '{0, 0, 64'h8000000000000000, 64'h1, 0, 0, 0, 0}
    };

    initial
    begin
        int left;
        int len;
        key_word = '{default: '0};
        iv_word  = '{default: '0};
        decrypt_mode = 1'b0;
        chain_block  = '0;
        build_schedule();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                end_burst();
                wait_idle();
                write_reg(directed[i].idx, directed[i].hi);
            end
            else
                send_block(directed[i].hi, directed[i].lo, directed[i].first,
                           directed[i].known, directed[i].exp_hi, directed[i].exp_lo);
        end
        end_burst();

        for (int phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            quiet = (phase == 4);
            for (int r = 0; r < 4; r++)
                if (phase < 2 || $urandom_range(0, 2) == 0)
                    write_reg(r[2:0], phase == 0 ? '1 : (phase == 1 ? '0 : rand_word()));
            write_reg(acbc_pkg::REG_IV_HI, rand_word());
            write_reg(acbc_pkg::REG_IV_LO, rand_word());
            write_reg(acbc_pkg::REG_DIR, {$urandom, $urandom});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, rand_word());
            left = 85;
            while (left > 0)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len && left > 0; k++, left--)
                    send_block(rand_word(), rand_word(),
                               (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                               0, 0, 0);
            end
            end_burst();
        end

        wait_idle();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
